/* hw/rtl/modexp_pkg.sv */
// Package for the modular exponentiation block: field widths, defaults and the
// sequencer state type. Used by modexp_seq and modular_exponentiation.
package modexp_pkg;

    // Field widths of the stream payloads.
    localparam int BASE_W      = 30;
    localparam int EXP_W       = 63;
    localparam int OUT_W       = 30;
    localparam int CFG_W       = 30;
    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 32;

    // Parameter defaults.
    localparam int EXP_BITS_DEF = 63;
    localparam int MOD_BITS_DEF = 30;

    // Modulus after reset: the prime 1e9 + 7.
    localparam logic [31:0] MOD_RESET = 32'd1000000007;

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_SQUARE,
        S_MULT,
        S_DONE
    } t_seq_state;

endpackage

/* hw/rtl/modexp_mulmod.sv */
// Shared modular multiplier: x * y mod m, one bit of x per cycle (interleaved
// shift-add with conditional subtraction). Depends on nothing outside itself.
module modexp_mulmod #(
    parameter int MOD_BITS = 30,
    parameter int XW       = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [XW-1:0]       i_x,
    input  logic [MOD_BITS-1:0] i_y,
    input  logic [MOD_BITS-1:0] i_mod,
    output logic                o_done,
    output logic [MOD_BITS-1:0] o_result
);

    localparam int MW = MOD_BITS + 2;
    localparam int CW = $clog2(XW + 1);

    logic                r_busy;
    logic                r_done;
    logic [CW-1:0]       r_cnt;
    logic [XW-1:0]       r_x;
    logic [MOD_BITS-1:0] r_y;
    logic [MW-1:0]       r_mod;
    logic [MW-1:0]       r_mod2;
    logic [MOD_BITS-1:0] r_acc;

    logic [MW-1:0]       w_sum;
    logic [MW-1:0]       w_sub1;
    logic [MW-1:0]       w_sub2;
    logic [MOD_BITS-1:0] n_acc;

    // The running value stays below m and y is below m, so the sum stays below 3m.
    always_comb begin
        w_sum  = {1'b0, r_acc, 1'b0} + (r_x[XW-1] ? MW'(r_y) : '0);
        w_sub1 = w_sum - r_mod;
        w_sub2 = w_sum - r_mod2;
        if (w_sum >= r_mod2) begin
            n_acc = w_sub2[MOD_BITS-1:0];
        end else if (w_sum >= r_mod) begin
            n_acc = w_sub1[MOD_BITS-1:0];
        end else begin
            n_acc = w_sum[MOD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(XW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !r_busy) begin
            r_x    <= i_x;
            r_y    <= i_y;
            r_mod  <= MW'(i_mod);
            r_mod2 <= {1'b0, i_mod, 1'b0};
            r_acc  <= '0;
        end else if (r_busy) begin
            r_x   <= {r_x[XW-2:0], 1'b0};
            r_acc <= n_acc;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_acc;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("multiplier started while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("done without a preceding operation");

    a_busy_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0))
        else $error("busy with an exhausted bit count");

endmodule

/* hw/rtl/modexp_seq.sv */
// Square-and-multiply sequencer: scans the exponent from the top bit down and
// drives the shared multiplier. Depends on modexp_pkg and modexp_mulmod.
module modexp_seq #(
    parameter int EXP_BITS = 63,
    parameter int MOD_BITS = 30,
    parameter int XW       = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [XW-1:0]       i_base,
    input  logic [EXP_BITS-1:0] i_exp,
    input  logic [MOD_BITS-1:0] i_mod,
    output logic                o_res_valid,
    input  logic                i_res_ready,
    output logic [MOD_BITS-1:0] o_res
);

    localparam int IW = (EXP_BITS > 1) ? $clog2(EXP_BITS) : 1;

    modexp_pkg::t_seq_state r_state;
    modexp_pkg::t_seq_state n_state;

    logic                r_issued;
    logic [MOD_BITS-1:0] r_acc;
    logic [XW-1:0]       r_base;
    logic [EXP_BITS-1:0] r_exp;
    logic [IW-1:0]       r_idx;

    logic                w_mod_small;
    logic                w_bit;
    logic                w_last;
    logic                w_accept;
    logic                mm_start;
    logic [XW-1:0]       mm_x;
    logic [MOD_BITS-1:0] mm_y;
    logic                mm_done;
    logic [MOD_BITS-1:0] mm_result;

    assign w_mod_small = (i_mod < MOD_BITS'(2));
    assign w_bit       = r_exp[r_idx];
    assign w_last      = (r_idx == '0);
    assign w_accept    = i_valid && (r_state == modexp_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            modexp_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = w_mod_small ? modexp_pkg::S_DONE : modexp_pkg::S_REDUCE;
                end
            end
            modexp_pkg::S_REDUCE: begin
                if (mm_done) begin
                    n_state = modexp_pkg::S_SQUARE;
                end
            end
            modexp_pkg::S_SQUARE: begin
                if (mm_done) begin
                    if (w_bit) begin
                        n_state = modexp_pkg::S_MULT;
                    end else if (w_last) begin
                        n_state = modexp_pkg::S_DONE;
                    end
                end
            end
            modexp_pkg::S_MULT: begin
                if (mm_done) begin
                    n_state = w_last ? modexp_pkg::S_DONE : modexp_pkg::S_SQUARE;
                end
            end
            modexp_pkg::S_DONE: begin
                if (i_res_ready) begin
                    n_state = modexp_pkg::S_IDLE;
                end
            end
            default: n_state = modexp_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready     = 1'b0;
        o_res_valid = 1'b0;
        mm_start    = 1'b0;
        mm_x        = XW'(r_acc);
        mm_y        = r_acc;
        unique case (r_state)
            modexp_pkg::S_IDLE: begin
                o_ready = 1'b1;
            end
            modexp_pkg::S_REDUCE: begin
                // The raw base times one gives the base reduced modulo m.
                mm_start = !r_issued;
                mm_x     = r_base;
                mm_y     = MOD_BITS'(1);
            end
            modexp_pkg::S_SQUARE: begin
                mm_start = !r_issued;
            end
            modexp_pkg::S_MULT: begin
                mm_start = !r_issued;
                mm_x     = r_base;
            end
            modexp_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= modexp_pkg::S_IDLE;
            r_issued <= 1'b0;
        end else begin
            r_state <= n_state;
            if (mm_start) begin
                r_issued <= 1'b1;
            end else if (mm_done) begin
                r_issued <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_base <= i_base;
            r_exp  <= i_exp;
            r_idx  <= IW'(EXP_BITS - 1);
            r_acc  <= w_mod_small ? '0 : MOD_BITS'(1);
        end else if (mm_done) begin
            if (r_state == modexp_pkg::S_REDUCE) begin
                r_base <= XW'(mm_result);
            end else begin
                r_acc <= mm_result;
            end
            // Move to the next exponent bit once its optional multiply is behind us.
            if (((r_state == modexp_pkg::S_SQUARE) && !w_bit) ||
                (r_state == modexp_pkg::S_MULT)) begin
                if (!w_last) begin
                    r_idx <= r_idx - 1'b1;
                end
            end
        end
    end

    modexp_mulmod #(
        .MOD_BITS (MOD_BITS),
        .XW       (XW)
    ) u_mulmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (mm_start),
        .i_x      (mm_x),
        .i_y      (mm_y),
        .i_mod    (i_mod),
        .o_done   (mm_done),
        .o_result (mm_result)
    );

    assign o_res = r_acc;

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == modexp_pkg::S_DONE) |-> ((r_acc < i_mod) || w_mod_small))
        else $error("result not fully reduced");

    a_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mm_done |-> r_issued)
        else $error("multiplier result without a request");

    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == modexp_pkg::S_IDLE) |-> !r_issued)
        else $error("operation outstanding while idle");

endmodule

/* hw/rtl/modular_exponentiation.sv */
// Top level of the modular exponentiation block: modulus register, stream ports
// and output register. Depends on modexp_pkg and modexp_seq.
//
//  channel   | direction | handshake                        | payload
//  s_axis    | in        | i_s_axis_tvalid / o_s_axis_tready | base, exponent
//  m_axis    | out       | o_m_axis_tvalid / i_m_axis_tready | power_mod
//  cfg       | in        | i_cfg_wr_en (no wait)             | modulus
//
// Each multiplier pass scans XW bits of its first operand, XW = max(MOD_BITS, 30);
// a transaction needs 1 + EXP_BITS + ones(exponent) passes. The result then moves
// through the DONE state into the output register, and the input is ready again in
// the same cycle. A modulus below 2 goes straight from IDLE to DONE with a result of 0.
// Reset is synchronous and loads 1e9 + 7. o_s_axis_tready is high only while the
// sequencer is idle; a finished result sits in the output register, so the next
// transaction starts while it waits to be taken. If that register is still full when
// the next result is ready, the sequencer holds its result and the input stays closed.
module modular_exponentiation #(
    parameter int EXP_BITS = modexp_pkg::EXP_BITS_DEF,
    parameter int MOD_BITS = modexp_pkg::MOD_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // [29:0] base, [92:30] exponent, [95:93] zero
    input  logic [modexp_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                               o_m_axis_tvalid,
    input  logic                               i_m_axis_tready,
    // [29:0] power_mod, [31:30] zero
    output logic [modexp_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                               i_cfg_wr_en,
    input  logic [modexp_pkg::CFG_W-1:0]       i_cfg_wr_data
);

    localparam int XW = (MOD_BITS > modexp_pkg::BASE_W) ? MOD_BITS : modexp_pkg::BASE_W;
    localparam logic [31:0] ModReset = modexp_pkg::MOD_RESET;

    logic [MOD_BITS-1:0]          r_mod;
    logic                         r_tvalid;
    logic [modexp_pkg::OUT_W-1:0] r_tdata;

    logic [31:0]                  w_cfg;
    logic [31:0]                  w_res;
    logic [XW-1:0]                w_base;
    logic [EXP_BITS-1:0]          w_exp;
    logic                         seq_ready;
    logic                         seq_res_valid;
    logic                         seq_res_ready;
    logic [MOD_BITS-1:0]          seq_res;

    assign w_cfg  = 32'(i_cfg_wr_data);
    assign w_res  = 32'(seq_res);
    assign w_base = XW'(i_s_axis_tdata[modexp_pkg::BASE_W-1:0]);
    assign w_exp  = i_s_axis_tdata[modexp_pkg::BASE_W +: EXP_BITS];

    assign seq_res_ready = !r_tvalid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod    <= ModReset[MOD_BITS-1:0];
            r_tvalid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_mod <= w_cfg[MOD_BITS-1:0];
            end
            if (seq_res_valid && seq_res_ready) begin
                r_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (seq_res_valid && seq_res_ready) begin
            r_tdata <= w_res[modexp_pkg::OUT_W-1:0];
        end
    end

    modexp_seq #(
        .EXP_BITS (EXP_BITS),
        .MOD_BITS (MOD_BITS),
        .XW       (XW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_s_axis_tvalid),
        .o_ready     (seq_ready),
        .i_base      (w_base),
        .i_exp       (w_exp),
        .i_mod       (r_mod),
        .o_res_valid (seq_res_valid),
        .i_res_ready (seq_res_ready),
        .o_res       (seq_res)
    );

    assign o_s_axis_tready = seq_ready;
    assign o_m_axis_tvalid = r_tvalid;
    assign o_m_axis_tdata  = modexp_pkg::OUT_TDATA_W'(r_tdata);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input still open after a transaction was taken");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tvalid && !i_m_axis_tready) |-> !(seq_res_valid && seq_res_ready))
        else $error("pending result overwritten");

endmodule
